// ===== src/bmft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmft_pkg
// Shared types and constants for the block-mapped flash translation block.
// ----------------------------------------------------------------------------
package bmft_pkg;

    localparam int NUM_BLOCKS_DEF    = 16;
    localparam int PAGES_PER_BLK_DEF = 4;

    localparam int SECTOR_W = 6;
    localparam int PAGE_W   = 6;
    localparam int BLOCK_W  = 4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE  = 2'd3
    } flash_op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_UNMAPPED = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NO_FRESH = 2'd3
    } status_t;

endpackage

// ===== src/bmft_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/block_mapped_flash_translation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_mapped_flash_translation
// Block-mapped flash translation: maps sector requests to flash commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per item (s_action 0 read, 1 write; s_logical_sector).
//   m_ channel: one or more flash commands per request; m_last marks the final
//   command of a request. Status codes other than ok come with no command.
//   Map entry (valid, physical block, page-used bits) lives in one RAM with a
//   registered read: a request is read in the cycle it is accepted, modified
//   and written back in ST_LOOKUP once the output register is free.
//   Order: a single command is loaded into the output register from ST_LOOKUP;
//   a rewrite's first command comes from ST_READS, or ST_ERASE if no other page is used.
//   Flow: s_ready is high only in ST_IDLE, so no new request is taken until
//   every command of the current one has entered the output register. A rewrite
//   of a used page scans the pages in a read phase and a write phase.
//   Reset: after aresetn the map RAM is cleared one entry per cycle, all
//   NUM_BLOCKS entries, with s_ready low. The spare block resets to the last physical block.
//   Stall: results sit in an output register; while it holds a command and
//   m_ready is low the command sequence pauses. A finished request's last
//   command may wait while the next request is taken.
// ----------------------------------------------------------------------------
module block_mapped_flash_translation #(
    parameter int NUM_BLOCKS    = bmft_pkg::NUM_BLOCKS_DEF,
    parameter int PAGES_PER_BLK = bmft_pkg::PAGES_PER_BLK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [bmft_pkg::SECTOR_W-1:0] s_logical_sector,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bmft_pkg::flash_op_t           m_flash_op,
    output logic [bmft_pkg::PAGE_W-1:0]   m_flash_page,
    output logic [bmft_pkg::BLOCK_W-1:0]  m_flash_block,
    output bmft_pkg::status_t             m_status,
    output logic                          m_last
);

    import bmft_pkg::*;

    localparam int PBN_W   = $clog2(NUM_BLOCKS);
    localparam int OFF_W   = $clog2(PAGES_PER_BLK);
    localparam int ENT_W   = 1 + PBN_W + PAGES_PER_BLK;
    localparam int NUM_SEC = 2 ** SECTOR_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_READS,
        ST_ERASE,
        ST_WRITES,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;

    logic [PBN_W-1:0]         clr_reg, clr_next;
    logic [PBN_W-1:0]         fresh_reg, fresh_next;
    logic [PBN_W-1:0]         spare_reg, spare_next;
    logic [OFF_W-1:0]         idx_reg, idx_next;

    logic                     req_write_reg, req_write_next;
    logic                     req_oob_reg, req_oob_next;
    logic [PBN_W-1:0]         req_lbn_reg, req_lbn_next;
    logic [OFF_W-1:0]         req_off_reg, req_off_next;

    logic [PBN_W-1:0]         seq_old_reg, seq_old_next;
    logic [PBN_W-1:0]         seq_new_reg, seq_new_next;
    logic [PAGES_PER_BLK-1:0] seq_others_reg, seq_others_next;

    logic                     m_valid_reg, m_valid_next;
    flash_op_t                m_op_reg, m_op_next;
    logic [PAGE_W-1:0]        m_page_reg, m_page_next;
    logic [BLOCK_W-1:0]       m_block_reg, m_block_next;
    status_t                  m_status_reg, m_status_next;
    logic                     m_last_reg, m_last_next;

    logic                     ram_we, ram_re;
    logic [PBN_W-1:0]         ram_waddr, ram_raddr;
    logic [ENT_W-1:0]         ram_wdata, ram_rdata;

    logic [PBN_W-1:0]         in_lbn;
    logic [OFF_W-1:0]         in_off;
    logic                     in_oob;

    logic                     ent_valid;
    logic [PBN_W-1:0]         ent_pbn;
    logic [PAGES_PER_BLK-1:0] ent_used;
    logic [PAGES_PER_BLK-1:0] off_bit;
    logic                     out_free;

    function automatic logic [PAGE_W-1:0] page_of(input logic [PBN_W-1:0] pbn,
                                                  input logic [OFF_W-1:0] off);
        logic [31:0] full;
        full = 32'(pbn) * 32'(PAGES_PER_BLK) + 32'(off);
        return full[PAGE_W-1:0];
    endfunction

    bmft_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_BLOCKS)
    ) u_map_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // sector split: constant table over all sector codes
    always_comb begin
        in_lbn = '0;
        in_off = '0;
        for (int s = 0; s < NUM_SEC; s++) begin
            if (s_logical_sector == SECTOR_W'(s)) begin
                in_lbn = PBN_W'(s / PAGES_PER_BLK);
                in_off = OFF_W'(s % PAGES_PER_BLK);
            end
        end
    end

    assign in_oob = 32'(s_logical_sector) >= 32'(NUM_BLOCKS * PAGES_PER_BLK);

    assign ent_valid = ram_rdata[ENT_W-1];
    assign ent_pbn   = ram_rdata[PAGES_PER_BLK +: PBN_W];
    assign ent_used  = ram_rdata[PAGES_PER_BLK-1:0];
    assign off_bit   = {{(PAGES_PER_BLK-1){1'b0}}, 1'b1} << req_off_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == ST_IDLE);
    assign ram_re    = s_valid && s_ready;
    assign ram_raddr = in_lbn;

    always_comb begin
        logic              emit;
        flash_op_t         e_op;
        logic [PAGE_W-1:0] e_page;
        logic [BLOCK_W-1:0] e_block;
        status_t           e_status;
        logic              e_last;

        emit     = 1'b0;
        e_op     = OP_NONE;
        e_page   = '0;
        e_block  = '0;
        e_status = STAT_OK;
        e_last   = 1'b0;

        state_next      = state_reg;
        clr_next        = clr_reg;
        fresh_next      = fresh_reg;
        spare_next      = spare_reg;
        idx_next        = idx_reg;
        req_write_next  = req_write_reg;
        req_oob_next    = req_oob_reg;
        req_lbn_next    = req_lbn_reg;
        req_off_next    = req_off_reg;
        seq_old_next    = seq_old_reg;
        seq_new_next    = seq_new_reg;
        seq_others_next = seq_others_reg;

        ram_we    = 1'b0;
        ram_waddr = req_lbn_reg;
        ram_wdata = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == PBN_W'(NUM_BLOCKS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_write_next = s_action;
                    req_oob_next   = in_oob;
                    req_lbn_next   = in_lbn;
                    req_off_next   = in_off;
                    state_next     = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    priority if (req_oob_reg) begin
                        e_status = STAT_RANGE;
                    end else if (!req_write_reg) begin
                        if (ent_valid) begin
                            e_op   = OP_READ;
                            e_page = page_of(ent_pbn, req_off_reg);
                        end else begin
                            e_status = STAT_UNMAPPED;
                        end
                    end else if (!ent_valid) begin
                        if (fresh_reg >= PBN_W'(NUM_BLOCKS - 1)) begin
                            e_status = STAT_NO_FRESH;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b1, fresh_reg, off_bit};
                            fresh_next = fresh_reg + 1'b1;
                            e_op       = OP_WRITE;
                            e_page     = page_of(fresh_reg, req_off_reg);
                        end
                    end else if ((ent_used & off_bit) == '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, ent_pbn, ent_used | off_bit};
                        e_op      = OP_WRITE;
                        e_page    = page_of(ent_pbn, req_off_reg);
                    end else begin
                        // rewrite: move to the spare block, old block becomes spare
                        emit            = 1'b0;
                        e_last          = 1'b0;
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, spare_reg, ent_used};
                        spare_next      = ent_pbn;
                        seq_old_next    = ent_pbn;
                        seq_new_next    = spare_reg;
                        seq_others_next = ent_used & ~off_bit;
                        idx_next        = '0;
                        state_next      = ST_READS;
                    end
                end
            end
            ST_READS, ST_WRITES: begin
                if (!seq_others_reg[idx_reg] || out_free) begin
                    if (seq_others_reg[idx_reg]) begin
                        emit = 1'b1;
                        if (state_reg == ST_READS) begin
                            e_op   = OP_READ;
                            e_page = page_of(seq_old_reg, idx_reg);
                        end else begin
                            e_op   = OP_WRITE;
                            e_page = page_of(seq_new_reg, idx_reg);
                        end
                    end
                    if (idx_reg == OFF_W'(PAGES_PER_BLK - 1)) begin
                        idx_next   = '0;
                        state_next = (state_reg == ST_READS) ? ST_ERASE : ST_FINAL;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_ERASE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_op       = OP_ERASE;
                    e_block    = BLOCK_W'(seq_old_reg);
                    state_next = ST_WRITES;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_op       = OP_WRITE;
                    e_page     = page_of(seq_new_reg, req_off_reg);
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next  = m_valid_reg;
        m_op_next     = m_op_reg;
        m_page_next   = m_page_reg;
        m_block_next  = m_block_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_op_next     = e_op;
            m_page_next   = e_page;
            m_block_next  = e_block;
            m_status_next = e_status;
            m_last_next   = e_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            fresh_reg   <= '0;
            spare_reg   <= PBN_W'(NUM_BLOCKS - 1);
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fresh_reg   <= fresh_next;
            spare_reg   <= spare_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        req_write_reg  <= req_write_next;
        req_oob_reg    <= req_oob_next;
        req_lbn_reg    <= req_lbn_next;
        req_off_reg    <= req_off_next;
        seq_old_reg    <= seq_old_next;
        seq_new_reg    <= seq_new_next;
        seq_others_reg <= seq_others_next;
        m_op_reg       <= m_op_next;
        m_page_reg     <= m_page_next;
        m_block_reg    <= m_block_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_flash_op    = m_op_reg;
    assign m_flash_page  = m_page_reg;
    assign m_flash_block = m_block_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTH
    // no command can leave while the map is still being cleared
    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid)
        else $error("result presented during map clear");

    // an erase is always followed by the rewrite commands
    a_erase_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_flash_op == OP_ERASE) |-> !m_last)
        else $error("erase marked as last command");

    // error statuses carry no command and close the request
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_flash_op == OP_NONE && m_last))
        else $error("error status with a command or not last");

    // fresh allocation never reaches the reserved last block
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP && fresh_next != fresh_reg) |=>
            (fresh_reg <= PBN_W'(NUM_BLOCKS - 1) && $past(m_valid_next)))
        else $error("fresh block pointer out of range");
`endif

endmodule

// ===== tb/tb_block_mapped_flash_translation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_mapped_flash_translation
// Self-checking bench for the block-mapped flash translation block. It keeps
// its own copy of the block map, the page-used bits, the fresh pointer and the
// spare block. From these it computes the flash commands that each accepted
// request should produce. Commands from the block are checked in order against
// that list. Stimulus is a directed set of requests followed by random ones,
// mostly bursts of writes to one logical block. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_block_mapped_flash_translation;
    import bmft_pkg::*;

    localparam int NUM_BLK    = NUM_BLOCKS_DEF;
    localparam int PPB        = PAGES_PER_BLK_DEF;
    localparam int CLK_HALF   = 4;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 123;

    typedef struct packed {
        flash_op_t          op;
        logic [PAGE_W-1:0]  page;
        logic [BLOCK_W-1:0] blk;
        status_t            st;
        logic               last;
    } flash_cmd_t;

    typedef struct {
        logic                act;
        logic [SECTOR_W-1:0] sector;
        bit                  drain_first;
    } sector_req_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_action = 1'b0;
    logic [SECTOR_W-1:0] s_logical_sector = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    flash_op_t           m_flash_op;
    logic [PAGE_W-1:0]   m_flash_page;
    logic [BLOCK_W-1:0]  m_flash_block;
    status_t             m_status;
    logic                m_last;

    block_mapped_flash_translation #(
        .NUM_BLOCKS    (NUM_BLK),
        .PAGES_PER_BLK (PPB)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_logical_sector (s_logical_sector),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_flash_op       (m_flash_op),
        .m_flash_page     (m_flash_page),
        .m_flash_block    (m_flash_block),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    // shadow translation state
    bit                 map_valid [NUM_BLK];
    logic [BLOCK_W-1:0] map_pbn   [NUM_BLK];
    logic [PPB-1:0]     used_bits [NUM_BLK];
    int                 next_fresh;
    logic [BLOCK_W-1:0] spare_pbn;

    sector_req_t pending_reqs[$];
    flash_cmd_t  expected_cmds[$];

    int src_idle_pct = 27;
    int snk_idle_pct = 56;
    int total_reqs   = 0;
    int reqs_taken   = 0;
    int cmds_checked = 0;
    int errors       = 0;
    int idle_cycles  = 0;
    int n_rewrites   = 0;
    int n_unmapped   = 0;
    int n_no_fresh   = 0;
    bit s_taken      = 1'b0;

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic logic [PAGE_W-1:0] page_of(input logic [BLOCK_W-1:0] pbn, input int off);
        return PAGE_W'(int'(pbn) * PPB + off);
    endfunction

    function automatic flash_cmd_t mk_cmd(input flash_op_t op, input logic [PAGE_W-1:0] page,
                                          input logic [BLOCK_W-1:0] blk, input status_t st);
        flash_cmd_t c;
        c.op   = op;
        c.page = page;
        c.blk  = blk;
        c.st   = st;
        c.last = 1'b0;
        return c;
    endfunction

    task automatic predict_flash_cmds(input logic act, input logic [SECTOR_W-1:0] sector);
        flash_cmd_t         cmds [$];
        int                 lbn;
        int                 off;
        logic [BLOCK_W-1:0] pbn;
        logic [BLOCK_W-1:0] newb;
        logic [PPB-1:0]     bitm;
        logic [PPB-1:0]     others;
        if (int'(sector) >= NUM_BLK * PPB) begin
            cmds.push_back(mk_cmd(OP_NONE, '0, '0, STAT_RANGE));
        end else begin
            lbn  = int'(sector) / PPB;
            off  = int'(sector) % PPB;
            bitm = PPB'(1) << off;
            pbn  = map_pbn[lbn];
            if (!act) begin
                if (map_valid[lbn]) begin
                    cmds.push_back(mk_cmd(OP_READ, page_of(pbn, off), '0, STAT_OK));
                end else begin
                    cmds.push_back(mk_cmd(OP_NONE, '0, '0, STAT_UNMAPPED));
                    n_unmapped++;
                end
            end else if (!map_valid[lbn]) begin
                if (next_fresh >= NUM_BLK - 1) begin
                    cmds.push_back(mk_cmd(OP_NONE, '0, '0, STAT_NO_FRESH));
                    n_no_fresh++;
                end else begin
                    pbn = BLOCK_W'(next_fresh);
                    next_fresh++;
                    map_valid[lbn] = 1'b1;
                    map_pbn[lbn]   = pbn;
                    used_bits[lbn] = bitm;
                    cmds.push_back(mk_cmd(OP_WRITE, page_of(pbn, off), '0, STAT_OK));
                end
            end else if ((used_bits[lbn] & bitm) == '0) begin
                used_bits[lbn] |= bitm;
                cmds.push_back(mk_cmd(OP_WRITE, page_of(pbn, off), '0, STAT_OK));
            end else begin
                // rewrite: copy used pages out, erase, write them into the spare
                others = used_bits[lbn] & ~bitm;
                newb   = spare_pbn;
                for (int i = 0; i < PPB; i++)
                    if (others[i])
                        cmds.push_back(mk_cmd(OP_READ, page_of(pbn, i), '0, STAT_OK));
                cmds.push_back(mk_cmd(OP_ERASE, '0, pbn, STAT_OK));
                for (int i = 0; i < PPB; i++)
                    if (others[i])
                        cmds.push_back(mk_cmd(OP_WRITE, page_of(newb, i), '0, STAT_OK));
                cmds.push_back(mk_cmd(OP_WRITE, page_of(newb, off), '0, STAT_OK));
                map_pbn[lbn] = newb;
                spare_pbn    = pbn;
                n_rewrites++;
            end
        end
        for (int i = 0; i < cmds.size(); i++) begin
            cmds[i].last = (i == cmds.size() - 1);
            expected_cmds.push_back(cmds[i]);
        end
    endtask

    task automatic add_request(input logic act, input int sector, input bit drain_first);
        sector_req_t r;
        r.act         = act;
        r.sector      = SECTOR_W'(sector);
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // driver: new request and ready change on the falling edge
    always @(negedge aclk) begin
        sector_req_t nxt;
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (!s_valid || s_taken) begin
                if (pending_reqs.size() != 0 &&
                    !(pending_reqs[0].drain_first && expected_cmds.size() != 0) &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid          <= 1'b1;
                    s_action         <= nxt.act;
                    s_logical_sector <= nxt.sector;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: request acceptance feeds the predictor, commands are checked
    always @(posedge aclk) begin
        flash_cmd_t exp_c;
        flash_cmd_t got;
        bit         moved;
        s_taken = 1'b0;
        moved   = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_taken = 1'b1;
                moved   = 1'b1;
                reqs_taken++;
                predict_flash_cmds(s_action, s_logical_sector);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                got.op   = m_flash_op;
                got.page = m_flash_page;
                got.blk  = m_flash_block;
                got.st   = m_status;
                got.last = m_last;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command op=%0d page=%0d block=%0d status=%0d last=%0b",
                             $time, got.op, got.page, got.blk, got.st, got.last);
                    errors++;
                end else begin
                    exp_c = expected_cmds.pop_front();
                    cmds_checked++;
                    if (got !== exp_c) begin
                        $display("%0t: command mismatch: expected op=%0d page=%0d block=%0d status=%0d last=%0b",
                                 $time, exp_c.op, exp_c.page, exp_c.blk, exp_c.st, exp_c.last);
                        $display("%0t:                   actual   op=%0d page=%0d block=%0d status=%0d last=%0b",
                                 $time, got.op, got.page, got.blk, got.st, got.last);
                        errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("** block_mapped_flash_translation: FAILED **");
        $finish;
    end

    initial begin
        int lbn;
        int len;
        for (int i = 0; i < NUM_BLK; i++) begin
            map_valid[i] = 1'b0;
            map_pbn[i]   = '0;
            used_bits[i] = '0;
        end
        next_fresh = 0;
        spare_pbn  = BLOCK_W'(NUM_BLK - 1);

        // directed part
        add_request(1'b0, 5, 1'b0);           // read of unmapped block
        add_request(1'b1, 0, 1'b0);           // first write maps a fresh block
        add_request(1'b0, 0, 1'b0);
        add_request(1'b0, 2, 1'b0);           // read of a page never written
        add_request(1'b1, 1, 1'b0);
        add_request(1'b1, 2, 1'b0);
        add_request(1'b1, 0, 1'b0);           // rewrite, copies pages 1 and 2
        add_request(1'b1, 3, 1'b0);
        add_request(1'b1, 3, 1'b1);           // full-block rewrite after a drain
        add_request(1'b0, 63, 1'b0);
        add_request(1'b1, 63, 1'b0);
        add_request(1'b0, 63, 1'b0);
        // map every remaining logical block until the fresh pool runs out
        for (int k = 1; k < NUM_BLK - 1; k++) add_request(1'b1, k * PPB, 1'b0);
        add_request(1'b0, (NUM_BLK - 2) * PPB, 1'b0);

        // random part: mostly write bursts to one logical block
        while (total_reqs < 27 + N_RANDOM) begin
            if ($urandom_range(0, 99) < 60) begin
                lbn = $urandom_range(0, NUM_BLK - 1);
                len = $urandom_range(2, 6);
                for (int j = 0; j < len; j++)
                    add_request($urandom_range(0, 99) < 85, lbn * PPB + $urandom_range(0, PPB - 1),
                                $urandom_range(0, 49) == 0);
            end else begin
                add_request(1'($urandom_range(0, 1)), $urandom_range(0, 63), 1'b0);
            end
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (reqs_taken < total_reqs / 3) @(posedge aclk);
        src_idle_pct = 56;
        snk_idle_pct = 27;
        while (reqs_taken < (2 * total_reqs) / 3) @(posedge aclk);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (reqs_taken < total_reqs || expected_cmds.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (expected_cmds.size() != 0) begin
            $display("%0t: %0d expected commands never arrived", $time, expected_cmds.size());
            errors++;
        end
        $display("Covered %0d requests and %0d flash commands: %0d block rewrites,",
                 reqs_taken, cmds_checked, n_rewrites);
        $display("%0d reads of unmapped blocks, %0d writes refused for lack of a fresh block.",
                 n_unmapped, n_no_fresh);
        if (errors == 0) begin
            $display("** block_mapped_flash_translation: PASSED **");
        end else begin
            $display("** block_mapped_flash_translation: FAILED **");
        end
        $finish;
    end

endmodule
